// ===== sv/kmd_pkg.sv =====
package kmd_pkg;

  // Default matrix size.
  localparam int KMD_ROWS = 8;
  localparam int KMD_COLS = 16;

  // Field widths of the item streams.
  localparam int ROW_W       = 3;
  localparam int COL_W       = 4;
  localparam int NOW_W       = 32;
  localparam int LOCK_W      = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Lockout length after reset, in milliseconds.
  localparam logic [LOCK_W-1:0] LOCK_RESET = 16'd10;

  // Debounce phase of one key.
  typedef enum logic [1:0] {
    PH_RELEASED       = 2'd0,
    PH_PRESS_BOUNCE   = 2'd1,
    PH_PRESSED        = 2'd2,
    PH_RELEASE_BOUNCE = 2'd3
  } phase_t;

  // One entry of the key store.
  typedef struct packed {
    phase_t             phase;
    logic [NOW_W-1:0]   stamp;
  } key_entry_t;

  // Write request from the update stage to the key store.
  typedef struct packed {
    logic       en;
    key_entry_t entry;
  } key_wr_t;

endpackage

// ===== sv/kmd_key_store.sv =====
module kmd_key_store #(
  parameter int NKEYS = 128,
  parameter int IDX_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output kmd_pkg::key_entry_t rd_entry,
  input  kmd_pkg::key_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_idx
);
  import kmd_pkg::*;

  key_entry_t           mem [NKEYS];
  key_entry_t           rd_data;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [NKEYS-1:0]     written;
  logic                 last_vld;
  logic [IDX_W-1:0]     last_idx;
  key_entry_t           last_entry;

  // Synchronous memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Read address and the most recent write, kept for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      last_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr_idx] <= 1'b1;
        last_vld        <= 1'b1;
      end
    end
    if (rd_en) begin
      rd_idx_q <= rd_idx;
    end
    if (wr.en) begin
      last_idx   <= wr_idx;
      last_entry <= wr.entry;
    end
  end

  // The latest write to an address is always its current value, so it wins.
  // An entry never written since reset reads as released with a zero stamp.
  always_comb begin
    if (last_vld && (last_idx == rd_idx_q)) begin
      rd_entry = last_entry;
    end else if (!written[rd_idx_q]) begin
      rd_entry = '0;
    end else begin
      rd_entry = rd_data;
    end
  end

endmodule

// ===== sv/key_matrix_debouncer.sv =====
// Eager debouncer for every key of a ROWS x COLS key matrix.
// Input items arrive on the s_axis channel, one raw sample of one key each:
// row, column, the pressed sample and the current millisecond time in tdata,
// and tlast marking the last sample of a full scan. Every input item gives
// exactly one result item on the m_axis channel: edge flag, the key's
// pressed view and the OR of edges over the current scan.
// The lockout length in milliseconds is written through cfg_we/cfg_wdata; the user
// must write it while no item is in flight, which the block does not enforce.
// An accepted item passes the update stage and the result register before
// it shows on m_axis. One item is accepted every cycle unless the pipe is
// full; per-key state lives in a store with a registered read, and a key
// sampled in back-to-back items gets the previous item's write forwarded.
// When the receiver stalls, the result register and the update stage hold
// and s_axis_tready drops only once both are full.
// Reset makes every key released with a zero stamp, clears the scan OR and
// sets the lockout to 10 ms; it takes effect at once, with no clearing pass.
module key_matrix_debouncer #(
  parameter int ROWS = kmd_pkg::KMD_ROWS,
  parameter int COLS = kmd_pkg::KMD_COLS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row [2:0], col [6:3], sample_down [7], now_ms [39:8]
  input  logic [kmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // scan_end
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // edge_res [0], key_down [1], scan_changed [2], zero [7:3]
  output logic [kmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [kmd_pkg::LOCK_W-1:0]          cfg_wdata
);
  import kmd_pkg::*;

  // Row input has only ROW_W bits, so at most 2**ROW_W rows are reachable.
  localparam int ROWS_EFF = (ROWS < (1 << ROW_W)) ? ROWS : (1 << ROW_W);
  localparam int NKEYS    = ROWS_EFF * COLS;
  localparam int IDX_W    = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic               in_down;
  logic [NOW_W-1:0]   in_now;
  logic               in_fire;
  logic               in_range;
  logic [IDX_W-1:0]   in_idx;

  logic               s1_valid;
  logic               s1_range;
  logic [IDX_W-1:0]   s1_idx;
  logic               s1_down;
  logic [NOW_W-1:0]   s1_now;
  logic               s1_scan_end;
  logic               s1_fire;
  logic               out_free;

  logic [LOCK_W-1:0]  lockout_ms;
  logic               scan_accum;
  logic               out_valid;
  logic               out_edge;
  logic               out_key_down;
  logic               out_changed;

  key_entry_t         cur;
  key_entry_t         upd;
  key_wr_t            wr;
  logic [NOW_W-1:0]   elapsed;
  logic               lock_over;
  logic               edge_next;
  logic               key_down_next;
  logic               changed_next;

  // Unpack the input item.
  assign in_row  = s_axis_tdata[ROW_W-1:0];
  assign in_col  = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_down = s_axis_tdata[ROW_W+COL_W];
  assign in_now  = s_axis_tdata[ROW_W+COL_W+NOW_W:ROW_W+COL_W+1];

  // Handshake: the pipe moves whenever the result register is free.
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_fire       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Key index of the sampled key; keys off the matrix map to entry zero.
  assign in_range = (int'(in_row) < ROWS) && (int'(in_col) < COLS);
  always_comb begin
    if (in_range) begin
      in_idx = IDX_W'(IDX_W'(in_row) * IDX_W'(COLS)) + IDX_W'(in_col);
    end else begin
      in_idx = '0;
    end
  end

  // Lockout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms <= LOCK_RESET;
    end else if (cfg_we) begin
      lockout_ms <= cfg_wdata;
    end
  end

  // Update stage registers, loaded while the store read is in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (in_fire) begin
      s1_range    <= in_range;
      s1_idx      <= in_idx;
      s1_down     <= in_down;
      s1_now      <= in_now;
      s1_scan_end <= s_axis_tlast;
    end
  end

  kmd_key_store #(
    .NKEYS (NKEYS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_idx   (in_idx),
    .rd_entry (cur),
    .wr       (wr),
    .wr_idx   (s1_idx)
  );

  // Lockout check with wrapping time difference.
  assign elapsed   = s1_now - cur.stamp;
  assign lock_over = elapsed >= {{(NOW_W-LOCK_W){1'b0}}, lockout_ms};

  // Phase step of the sampled key.
  always_comb begin
    upd       = cur;
    edge_next = 1'b0;
    case (cur.phase)
      PH_RELEASED: begin
        if (s1_down) begin
          upd.phase = PH_PRESS_BOUNCE;
          upd.stamp = s1_now;
          edge_next = 1'b1;
        end
      end
      PH_PRESS_BOUNCE: begin
        if (lock_over) begin
          upd.phase = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!s1_down) begin
          upd.phase = PH_RELEASE_BOUNCE;
          upd.stamp = s1_now;
          edge_next = 1'b1;
        end
      end
      default: begin
        if (lock_over) begin
          upd.phase = PH_RELEASED;
        end
      end
    endcase
    if (!s1_range) begin
      edge_next = 1'b0;
    end
  end

  assign key_down_next = s1_range &&
                         ((upd.phase == PH_PRESS_BOUNCE) || (upd.phase == PH_PRESSED));
  assign changed_next  = scan_accum || edge_next;
  assign wr            = {s1_fire && s1_range, upd};

  // Scan accumulator and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_accum <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_fire) begin
        scan_accum <= s1_scan_end ? 1'b0 : changed_next;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_fire) begin
      out_edge     <= edge_next;
      out_key_down <= key_down_next;
      out_changed  <= changed_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_changed, out_key_down, out_edge};

endmodule

// ===== sim/debounce_checker.sv =====
`timescale 1ns / 100ps

module debounce_checker #(
  parameter int ROWS = kmd_pkg::KMD_ROWS,
  parameter int COLS = kmd_pkg::KMD_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [kmd_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [kmd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [kmd_pkg::LOCK_W-1:0]      cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);
  import kmd_pkg::*;

  // Result fields, packed so that edge_res sits in bit 0 as on m_axis.
  typedef struct packed {
    logic scan_changed;
    logic key_down;
    logic edge_res;
  } key_result_t;

  typedef struct {
    int          seq;
    key_result_t res;
  } awaited_t;

  // Private copy of the key store, the scan OR and the lockout length.
  phase_t            phase_mem [ROWS*COLS];
  logic [NOW_W-1:0]  stamp_mem [ROWS*COLS];
  logic              scan_or;
  logic [LOCK_W-1:0] lock_len;

  awaited_t awaited_results [$];
  int       item_seq;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    item_seq    = 0;
  end

  // Advance one key's debouncer by one sample and form its result.
  function automatic key_result_t debounce_sample(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col,
                                                  logic down,
                                                  logic [NOW_W-1:0] now,
                                                  logic last);
    key_result_t      r;
    int               idx;
    phase_t           ph;
    logic [NOW_W-1:0] elapsed;
    logic             lock_done;
    r = '0;
    if (int'(row) < ROWS && int'(col) < COLS) begin
      idx       = int'(row) * COLS + int'(col);
      ph        = phase_mem[idx];
      elapsed   = now - stamp_mem[idx];
      lock_done = (elapsed >= NOW_W'(lock_len));
      case (ph)
        PH_RELEASED: begin
          if (down) begin
            ph             = PH_PRESS_BOUNCE;
            stamp_mem[idx] = now;
            r.edge_res     = 1'b1;
          end
        end
        PH_PRESS_BOUNCE: begin
          if (lock_done) ph = PH_PRESSED;
        end
        PH_PRESSED: begin
          if (!down) begin
            ph             = PH_RELEASE_BOUNCE;
            stamp_mem[idx] = now;
            r.edge_res     = 1'b1;
          end
        end
        default: begin
          if (lock_done) ph = PH_RELEASED;
        end
      endcase
      phase_mem[idx] = ph;
      r.key_down     = (ph == PH_PRESS_BOUNCE || ph == PH_PRESSED);
    end
    // Samples outside the matrix still take part in the scan OR.
    r.scan_changed = scan_or | r.edge_res;
    scan_or        = last ? 1'b0 : r.scan_changed;
    return r;
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin : watch
    int          k;
    awaited_t    w;
    key_result_t got;
    if (rst) begin
      for (k = 0; k < ROWS*COLS; k++) begin
        phase_mem[k] = PH_RELEASED;
        stamp_mem[k] = '0;
      end
      scan_or  = 1'b0;
      lock_len = LOCK_RESET;
      awaited_results.delete();
    end else begin
      // Results are checked first so that one cannot match an item of this edge.
      if (m_tvalid && m_tready) begin
        got = m_tdata[2:0];
        if (awaited_results.size() == 0) begin
          report_failure($sformatf("result with no item pending, tdata=%02h", m_tdata));
        end else begin
          w = awaited_results.pop_front();
          if (got != w.res || m_tdata[7:3] != '0) begin
            report_failure($sformatf(
              "item %0d: expected edge=%0d key_down=%0d scan_changed=%0d, got tdata=%02h",
              w.seq, w.res.edge_res, w.res.key_down, w.res.scan_changed, m_tdata));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        w.seq = item_seq;
        w.res = debounce_sample(s_tdata[2:0], s_tdata[6:3], s_tdata[7],
                                s_tdata[39:8], s_tlast);
        awaited_results.push_back(w);
        item_seq++;
      end
      if (cfg_we) lock_len = cfg_wdata;
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import kmd_pkg::*;

  // Matrix size of the block's defaults.
  localparam int MTX_ROWS = KMD_ROWS;
  localparam int MTX_COLS = KMD_COLS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 200;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [LOCK_W-1:0]      cfg_wdata;
  int                     fail_count;
  int                     outstanding;

  int               items_sent;
  bit               tx_quiet;
  logic [NOW_W-1:0] clock_ms;
  bit               level_mem [0:127];
  logic [2:0]       act_row [6];
  logic [3:0]       act_col [6];

  key_matrix_debouncer #(
    .ROWS (MTX_ROWS),
    .COLS (MTX_COLS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  debounce_checker #(
    .ROWS (MTX_ROWS),
    .COLS (MTX_COLS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tlast     (s_axis_tlast),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one key sample and wait until it is accepted.
  task automatic key_sample(logic [2:0] row, logic [3:0] col, logic down,
                            logic [NOW_W-1:0] now, logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {now, down, col, row};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and let every pending result come out.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lockout(logic [LOCK_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Keys that follow a level with bounce noise, on a small set of busy keys
  // plus stray samples anywhere in the address space.
  task automatic random_run(int count);
    int         k;
    int         slot;
    logic [2:0] r;
    logic [3:0] c;
    logic       d;
    for (slot = 0; slot < 6; slot++) begin
      act_row[slot] = 3'($urandom_range(0, MTX_ROWS - 1));
      act_col[slot] = 4'($urandom_range(0, MTX_COLS - 1));
    end
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        slot = $urandom_range(0, 5);
        r    = act_row[slot];
        c    = act_col[slot];
      end else begin
        r = 3'($urandom);
        c = 4'($urandom);
      end
      if ($urandom_range(0, 9) == 0) level_mem[{r, c}] = !level_mem[{r, c}];
      d = level_mem[{r, c}];
      if ($urandom_range(0, 99) < 15) d = !d;
      // Mostly slow time, sometimes a jump anywhere, which also wraps.
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 3);
      key_sample(r, c, d, clock_ms, $urandom_range(0, 7) == 0);
    end
  endtask

  // Receiver: random stalls, one long hold-off once the stream is well going.
  initial begin : receiver
    int stall_left;
    bit rx_quiet;
    bit hold_done;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    rx_quiet      = 1'b0;
    hold_done     = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 79) == 0) rx_quiet = !rx_quiet;
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(rx_quiet);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[key_matrix_debouncer] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    items_sent    = 0;
    tx_quiet      = 1'b0;
    clock_ms      = '0;
    foreach (level_mem[i]) level_mem[i] = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full press and release with the reset lockout, across the time wrap.
    key_sample(3'd0, 4'd0, 1'b1, 32'hFFFF_FFFA, 1'b0);
    key_sample(3'd0, 4'd0, 1'b0, 32'hFFFF_FFFC, 1'b0);
    key_sample(3'd0, 4'd0, 1'b1, 32'h0000_0003, 1'b0);
    key_sample(3'd0, 4'd0, 1'b1, 32'h0000_0004, 1'b1);
    key_sample(3'd0, 4'd0, 1'b1, 32'h0000_0005, 1'b0);
    key_sample(3'd0, 4'd0, 1'b0, 32'h0000_0006, 1'b0);
    key_sample(3'd0, 4'd0, 1'b1, 32'h0000_000F, 1'b0);
    key_sample(3'd0, 4'd0, 1'b1, 32'h0000_0010, 1'b0);
    key_sample(3'd0, 4'd0, 1'b1, 32'h0000_0011, 1'b1);
    // Last key of the matrix, then other corner keys inside one scan.
    key_sample(3'(MTX_ROWS - 1), 4'(MTX_COLS - 1), 1'b1, 32'hFFFF_FFFF, 1'b0);
    key_sample(3'd7, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0);
    key_sample(3'd7, 4'd0, 1'b1, 32'h0000_0000, 1'b0);
    key_sample(3'd0, 4'd15, 1'b0, 32'h0000_0000, 1'b1);
    key_sample(3'(MTX_ROWS - 1), 4'(MTX_COLS - 1), 1'b0, 32'h0000_0000, 1'b0);
    key_sample(3'(MTX_ROWS - 1), 4'(MTX_COLS - 1), 1'b0, 32'h0000_0009, 1'b1);
    random_run(150);
    drain();

    // Zero lockout: each bouncing phase ends on the next sample.
    write_lockout('0);
    key_sample(3'd3, 4'd7, 1'b1, 32'h8000_0000, 1'b0);
    key_sample(3'd3, 4'd7, 1'b0, 32'h8000_0000, 1'b0);
    key_sample(3'd3, 4'd7, 1'b0, 32'h8000_0000, 1'b0);
    key_sample(3'd3, 4'd7, 1'b0, 32'h8000_0000, 1'b1);
    random_run(120);
    drain();

    // Longest lockout.
    write_lockout('1);
    key_sample(3'd5, 4'd9, 1'b1, 32'h1234_5678, 1'b0);
    key_sample(3'd5, 4'd9, 1'b1, 32'h1234_5678 + 32'd65534, 1'b0);
    key_sample(3'd5, 4'd9, 1'b1, 32'h1234_5678 + 32'd65535, 1'b1);
    random_run(80);
    drain();

    write_lockout(LOCK_W'($urandom_range(2, 30)));
    random_run(150);
    drain();

    write_lockout(LOCK_W'(1));
    random_run(150);
    drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[key_matrix_debouncer] OK");
    end else begin
      $display("[key_matrix_debouncer] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kmd_pkg.sv
sv/kmd_key_store.sv
sv/key_matrix_debouncer.sv
sim/debounce_checker.sv
sim/testbench.sv
